// ===== rtl/afsk_modulator_dual_channel_assert.svh =====
// Assertion macros shared by the AFSK modulator RTL.
`ifndef AFSK_MODULATOR_DUAL_CHANNEL_ASSERT_SVH
`define AFSK_MODULATOR_DUAL_CHANNEL_ASSERT_SVH

// Clocked implication check, disabled while reset is asserted.
`define AFSK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define AFSK_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/afsk_dc_pkg.sv =====
// Package with types, constants and the cosine table of the AFSK modulator.
`timescale 1ns / 1ps
`default_nettype none

package afsk_dc_pkg;

  localparam int unsigned SAMPLES_PER_BIT = 22;
  localparam int unsigned PHASE_STEPS     = 6;
  localparam int unsigned TABLE_LEN       = 132;
  localparam int unsigned SAMPLE_BITS     = 16;
  localparam int unsigned WORD_BITS       = 32;
  localparam int unsigned HOLD_BITS       = 4;

  localparam int unsigned IDX_W   = $clog2(TABLE_LEN);
  localparam int unsigned CNT_W   = $clog2(SAMPLES_PER_BIT);
  localparam int unsigned PHASE_W = 3;

  localparam logic [IDX_W-1:0] MARK_STEP  = IDX_W'(6);
  localparam logic [IDX_W-1:0] SPACE_STEP = IDX_W'(11);
  localparam logic [IDX_W-1:0] TABLE_END  = IDX_W'(TABLE_LEN);
  localparam logic [CNT_W-1:0] LAST_CNT   = CNT_W'(SAMPLES_PER_BIT - 1);
  localparam logic [PHASE_W:0] PHASE_WRAP = (PHASE_W + 1)'(PHASE_STEPS);
  localparam logic [HOLD_BITS-1:0] HOLD_RESET = HOLD_BITS'(4);

  localparam logic TONE_SPACE = 1'b0;
  localparam logic TONE_MARK  = 1'b1;

  typedef struct packed {
    logic                 word_valid;
    logic [WORD_BITS-1:0] word;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic                   last;
    logic                   word_taken;
    logic                   ptt_on;
  } out_t;

  // One bit period as handed from the bit stepper to the sample sequencer.
  typedef struct packed {
    logic               tone_a;
    logic [PHASE_W-1:0] phase_a;
    logic [PHASE_W-1:0] phase_b;
    logic               word_taken;
    logic               ptt_on;
  } desc_t;

  typedef logic [TABLE_LEN-1:0][SAMPLE_BITS-1:0] rom_t;

  localparam int unsigned HALF_LEN = TABLE_LEN / 2;

  localparam logic [63:0] Q_ONE   = 64'h4000_0000_0000_0000;
  localparam logic [63:0] PI_Q62  = 64'hC90F_DAA2_2168_C235;
  localparam logic [63:0] HALF_64 = 64'(HALF_LEN);
  localparam logic [63:0] X_STEP  = PI_Q62 / HALF_64;
  localparam logic [63:0] X_REM   = PI_Q62 % HALF_64;
  localparam logic [63:0] AMP     = 64'((64'd1 << SAMPLE_BITS) - 64'd1);

  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Restoring long division, used only while the table is built.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Fixed-point (1 + cos) / 2 table entry, evaluated only at elaboration.
  function automatic logic [SAMPLE_BITS-1:0] rom_entry(input int unsigned k);
    int unsigned m;
    logic        neg;
    logic [63:0] m64;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] c;
    logic [63:0] h;
    logic [63:0] lo_p;
    logic [63:0] hi_p;
    logic [63:0] dv;
    logic [63:0] res;
    m   = k;
    neg = 1'b0;
    if (m > HALF_LEN) m = TABLE_LEN - m;
    if (2 * m > HALF_LEN) begin
      m   = HALF_LEN - m;
      neg = 1'b1;
    end
    if (4 * m == TABLE_LEN) begin
      c = 64'd0;
    end else begin
      m64 = 64'(m);
      x   = X_STEP * m64 + udiv64(X_REM * m64, HALF_64);
      x2  = mul_q62(x, x);
      t   = Q_ONE;
      c   = Q_ONE;
      for (int n = 1; n <= 14; n++) begin
        dv = 64'((2 * n - 1) * (2 * n));
        t  = udiv64(mul_q62(t, x2), dv);
        if ((n & 1) == 1) c = c - t;
        else c = c + t;
      end
    end
    h    = neg ? ((Q_ONE - c) >> 1) : ((Q_ONE + c) >> 1);
    lo_p = {32'd0, h[31:0]} * AMP;
    hi_p = {32'd0, h[63:32]} * AMP + (lo_p >> 32);
    res  = (hi_p + 64'h2000_0000) >> 30;
    return res[SAMPLE_BITS-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k < TABLE_LEN; k++) begin
      r[k] = rom_entry(k);
    end
    return r;
  endfunction

  localparam rom_t COS_ROM = build_rom();

  // Table index of sample zero for a given phase: (-22 * phase) mod 132.
  function automatic logic [IDX_W-1:0] start_index(input logic [PHASE_W-1:0] phase);
    logic [IDX_W-1:0] r;
    case (phase)
      3'd0:    r = IDX_W'(0);
      3'd1:    r = IDX_W'(110);
      3'd2:    r = IDX_W'(88);
      3'd3:    r = IDX_W'(66);
      3'd4:    r = IDX_W'(44);
      3'd5:    r = IDX_W'(22);
      3'd6:    r = IDX_W'(0);
      default: r = IDX_W'(110);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/afsk_modulator_dual_channel.sv =====
// Top level of the dual-channel AFSK modulator.
`timescale 1ns / 1ps
`default_nettype none

// Dual-channel AFSK modulator. Each input request is one bit-period tick,
// optionally offering a data word that is sent LSB first, with its highest set
// bit acting as the end marker. Every request produces exactly 22 result
// requests, one stereo sample each: channel A plays the current tone
// (mark = 6 table steps per sample, space = 11) and channel B plays the
// opposite tone, both read from a 132-entry raised-cosine table. The last
// sample of the bit period is flagged, and every sample of it also reports
// whether the offered word was taken and the transmitter keying level.
// The sample sequencer emits one stereo sample per cycle while the output side
// does not stall, from a single table read per channel. The bit stepper updates
// all state in the cycle a request is accepted and parks the bit period in a
// one-entry register, so the next request is accepted while the current one is
// still being played out. The first sample passes the bit-period register, the
// sequencer index registers and the output register. The keying hold count is
// written through the cfg port, which is always ready and should only be
// written while the block is idle; it resets to 4. There is no clearing pass
// after reset.

module afsk_modulator_dual_channel
  import afsk_dc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [HOLD_BITS-1:0] cfg_data
);

  // Handoff between the bit stepper and the sample sequencer.
  logic  desc_valid;
  logic  desc_ready;
  desc_t desc;

  // The hold register is a plain flop, so a write can always land.
  assign cfg_ready = 1'b1;

  afsk_dc_bit_step u_bit_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .desc       (desc)
  );

  // Plays one bit period out as 22 samples; the output register decouples
  // the downstream ready from the table read.
  afsk_dc_sample_gen u_sample_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc_valid (desc_valid),
    .desc_ready (desc_ready),
    .desc       (desc),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/afsk_dc_bit_step.sv =====
// Bit-period state update: shift register, tone, phases and transmitter keying.
`timescale 1ns / 1ps
`default_nettype none

`include "afsk_modulator_dual_channel_assert.svh"

module afsk_dc_bit_step
  import afsk_dc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  input  logic                 cfg_valid,
  input  logic [HOLD_BITS-1:0] cfg_data,
  output logic                 desc_valid,
  input  logic                 desc_ready,
  output desc_t                desc
);

  logic [WORD_BITS-1:0] shift_r;
  logic                 tone_r;
  logic [PHASE_W-1:0]   phase_a_r;
  logic [PHASE_W-1:0]   phase_b_r;
  logic [HOLD_BITS-1:0] cnt_r;
  logic                 ptt_r;
  logic [HOLD_BITS-1:0] hold_r;
  logic                 desc_valid_r;
  desc_t                desc_r;

  logic [WORD_BITS-1:0] shift_nxt;
  logic                 tone_nxt;
  logic [PHASE_W-1:0]   phase_a_nxt;
  logic [PHASE_W-1:0]   phase_b_nxt;
  logic [HOLD_BITS-1:0] cnt_nxt;
  logic                 ptt_nxt;
  logic                 taken;
  logic                 accept;
  logic [WORD_BITS-1:0] sw;
  logic [PHASE_W:0]     pa_inc;
  logic [PHASE_W:0]     pb_inc;

  assign accept     = in_valid && in_ready;
  assign in_ready   = !desc_valid_r || desc_ready;
  assign desc_valid = desc_valid_r;
  assign desc       = desc_r;

  always_comb begin
    cnt_nxt = cnt_r;
    ptt_nxt = ptt_r;
    if (cnt_r != '0) begin
      cnt_nxt = cnt_r - HOLD_BITS'(1);
      if (cnt_nxt == '0) ptt_nxt = 1'b0;
    end
    taken = (shift_r <= WORD_BITS'(1)) && in_data.word_valid;
    sw    = taken ? in_data.word : shift_r;
    if (taken && (cnt_nxt == '0)) begin
      ptt_nxt = 1'b1;
      cnt_nxt = hold_r;
    end
    tone_nxt  = tone_r;
    shift_nxt = sw;
    if (sw > WORD_BITS'(1)) begin
      tone_nxt  = sw[0];
      shift_nxt = sw >> 1;
      cnt_nxt   = hold_r;
    end else if (sw == WORD_BITS'(1)) begin
      tone_nxt  = ~tone_r;
      shift_nxt = '0;
    end
    pa_inc      = {1'b0, phase_a_r} + (PHASE_W + 1)'(1);
    pb_inc      = {1'b0, phase_b_r} + (PHASE_W + 1)'(1);
    phase_a_nxt = phase_a_r;
    phase_b_nxt = phase_b_r;
    if (tone_nxt == TONE_SPACE) begin
      phase_a_nxt = (pa_inc >= PHASE_WRAP) ? '0 : pa_inc[PHASE_W-1:0];
    end else begin
      phase_b_nxt = (pb_inc >= PHASE_WRAP) ? '0 : pb_inc[PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r      <= '0;
      tone_r       <= TONE_SPACE;
      phase_a_r    <= '0;
      phase_b_r    <= '0;
      cnt_r        <= '0;
      ptt_r        <= 1'b0;
      hold_r       <= HOLD_RESET;
      desc_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) hold_r <= cfg_data;
      if (accept) begin
        shift_r      <= shift_nxt;
        tone_r       <= tone_nxt;
        phase_a_r    <= phase_a_nxt;
        phase_b_r    <= phase_b_nxt;
        cnt_r        <= cnt_nxt;
        ptt_r        <= ptt_nxt;
        desc_valid_r <= 1'b1;
      end else if (desc_ready) begin
        desc_valid_r <= 1'b0;
      end
    end
  end

  // The descriptor carries the phases in use during this bit period.
  always_ff @(posedge clk) begin
    if (accept) begin
      desc_r.tone_a     <= tone_nxt;
      desc_r.phase_a    <= phase_a_r;
      desc_r.phase_b    <= phase_b_r;
      desc_r.word_taken <= taken;
      desc_r.ptt_on     <= ptt_nxt;
    end
  end

  `AFSK_ASSERT(a_phase_range, clk, rst_n,
    ({1'b0, phase_a_r} < PHASE_WRAP) && ({1'b0, phase_b_r} < PHASE_WRAP),
    "phase left its range")
  `AFSK_ASSERT(a_desc_hold, clk, rst_n, (desc_valid_r && !desc_ready) |=> desc_valid_r,
    "bit period dropped before the sequencer took it")

endmodule

`default_nettype wire

// ===== rtl/afsk_dc_sample_gen.sv =====
// Sample sequencer: walks the cosine table for both channels, one sample per cycle unless the output stalls.
`timescale 1ns / 1ps
`default_nettype none

`include "afsk_modulator_dual_channel_assert.svh"

module afsk_dc_sample_gen
  import afsk_dc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  desc_valid,
  output logic  desc_ready,
  input  desc_t desc,
  output logic  out_valid,
  input  logic  out_ready,
  output out_t  out_data
);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] idx_a_r;
  logic [IDX_W-1:0] idx_b_r;
  logic             tone_a_r;
  logic             taken_r;
  logic             ptt_r;
  logic             out_valid_r;
  out_t             out_data_r;

  logic             adv;
  logic             emit;
  logic             at_last;
  logic             take;
  logic [IDX_W-1:0] step_a;
  logic [IDX_W-1:0] step_b;
  logic [IDX_W-1:0] sum_a;
  logic [IDX_W-1:0] sum_b;
  logic [IDX_W-1:0] idx_a_nxt;
  logic [IDX_W-1:0] idx_b_nxt;

  assign adv        = !out_valid_r || out_ready;
  assign emit       = adv && busy_r;
  assign at_last    = (cnt_r == LAST_CNT);
  assign take       = desc_valid && (!busy_r || (emit && at_last));
  assign desc_ready = take;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  assign step_a    = (tone_a_r == TONE_MARK) ? MARK_STEP : SPACE_STEP;
  assign step_b    = (tone_a_r == TONE_MARK) ? SPACE_STEP : MARK_STEP;
  assign sum_a     = idx_a_r + step_a;
  assign sum_b     = idx_b_r + step_b;
  assign idx_a_nxt = (sum_a >= TABLE_END) ? (sum_a - TABLE_END) : sum_a;
  assign idx_b_nxt = (sum_b >= TABLE_END) ? (sum_b - TABLE_END) : sum_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (adv) out_valid_r <= 1'b0;
      if (take) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (emit) begin
        if (at_last) busy_r <= 1'b0;
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      idx_a_r  <= start_index(desc.phase_a);
      idx_b_r  <= start_index(desc.phase_b);
      tone_a_r <= desc.tone_a;
      taken_r  <= desc.word_taken;
      ptt_r    <= desc.ptt_on;
    end else if (emit) begin
      idx_a_r <= idx_a_nxt;
      idx_b_r <= idx_b_nxt;
    end
    if (emit) begin
      out_data_r.sample_a   <= COS_ROM[idx_a_r];
      out_data_r.sample_b   <= COS_ROM[idx_b_r];
      out_data_r.last       <= at_last;
      out_data_r.word_taken <= taken_r;
      out_data_r.ptt_on     <= ptt_r;
    end
  end

  `AFSK_ASSERT(a_cnt_range, clk, rst_n, busy_r |-> (cnt_r <= LAST_CNT),
    "sample count past end of bit period")
  `AFSK_ASSERT(a_idx_range, clk, rst_n,
    busy_r |-> ((idx_a_r < TABLE_END) && (idx_b_r < TABLE_END)),
    "table index out of range")
  `AFSK_ASSERT(a_last_ends, clk, rst_n, (emit && at_last && !take) |=> !busy_r,
    "sequencer still busy after final sample")

endmodule

`default_nettype wire
